[design/pfsa_pkg.sv]
package pfsa_pkg;

  // sizes
  localparam int PAGE_SLOTS     = 16;
  localparam int PAGE_W         = 4;
  localparam int ITEMS_MAX      = 64;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;
  localparam int LEN_W          = 5;
  localparam int OFF_W          = 12;
  localparam int SIZE_W         = 11;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 11;
  localparam int HEADER_BYTES   = 32;
  localparam int SLOT_HDR_BYTES = 8;

  // config reset values
  localparam logic [SIZE_W-1:0] ITEM_SIZE_RST = SIZE_W'(55);
  localparam logic [CNT_W-1:0]  IPP_RST       = CNT_W'(64);

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_SIZE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEMS_PER_PAGE = 1'b1;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOC     = 3'd0,
    ST_ALLOC_NEW = 3'd1,
    ST_FREED     = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_NO_PAGE   = 3'd4,
    ST_BAD_FREE  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NEW,
    S_FREE,
    S_FIN
  } fsm_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic step;
    logic take;
    logic new_page;
    logic do_free;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic list_end;
    logic page_hit;
  } dp_stat_t;

endpackage

[design/paged_fixed_slot_allocator_core.sv]
// channel   handshake          payload
// input     start / busy       in_command, in_free_page, in_free_index
// result    out_valid strobe   out_status, out_page, out_index, out_byte_offset,
//                              out_pages_in_use
// config    cfg_we             cfg_index, cfg_data
//
// a free passes through S_FREE and S_FIN; an allocate walks the page list in S_SCAN and
// then takes S_FIN when it lands in the page at list position k (0..15), or goes
// through S_NEW and S_FIN when it must start a page or finds none, after walking the
// whole list of n pages (0..16); the page list is walked one page a cycle, with a
// priority encoder over that page's free map
// busy drops as the result strobe rises, so the next item may be taken at the
// edge that takes the previous result
// synchronous active-low reset; the receiver cannot stall results
module paged_fixed_slot_allocator_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // item request
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_command,
  input  logic [pfsa_pkg::PAGE_W-1:0]          in_free_page,
  input  logic [pfsa_pkg::IDX_W-1:0]           in_free_index,
  // result
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [pfsa_pkg::PAGE_W-1:0]          out_page,
  output logic [pfsa_pkg::IDX_W-1:0]           out_index,
  output logic [pfsa_pkg::OFF_W-1:0]           out_byte_offset,
  output logic [pfsa_pkg::LEN_W-1:0]           out_pages_in_use,
  // register writes
  input  logic                                 cfg_we,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // command and status between controller and datapath
  pfsa_pkg::ctl_cmd_t cmd;
  pfsa_pkg::dp_stat_t stat;

  // sequencer: accept, walk the page list, start a page, free, deliver
  pfsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  // page tables, free maps, page list, offset arithmetic and result registers
  pfsa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_free_page     (in_free_page),
    .in_free_index    (in_free_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_page         (out_page),
    .out_index        (out_index),
    .out_byte_offset  (out_byte_offset),
    .out_pages_in_use (out_pages_in_use)
  );

endmodule

[design/pfsa_ctrl.sv]
module pfsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_command,
  input  pfsa_pkg::dp_stat_t stat,
  output pfsa_pkg::ctl_cmd_t cmd,
  output logic               busy
);

  pfsa_pkg::fsm_t state_r;
  pfsa_pkg::fsm_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfsa_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_command == pfsa_pkg::CMD_FREE) ? pfsa_pkg::S_FREE : pfsa_pkg::S_SCAN;
        end
      end
      pfsa_pkg::S_SCAN: begin
        if (stat.list_end) begin
          state_nxt = pfsa_pkg::S_NEW;
        end else if (stat.page_hit) begin
          state_nxt = pfsa_pkg::S_FIN;
        end
      end
      pfsa_pkg::S_NEW:  state_nxt = pfsa_pkg::S_FIN;
      pfsa_pkg::S_FREE: state_nxt = pfsa_pkg::S_FIN;
      pfsa_pkg::S_FIN:  state_nxt = pfsa_pkg::S_IDLE;
      default:          state_nxt = pfsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      pfsa_pkg::S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      pfsa_pkg::S_SCAN: begin
        cmd.take = !stat.list_end && stat.page_hit;
        cmd.step = !stat.list_end && !stat.page_hit;
      end
      pfsa_pkg::S_NEW:  cmd.new_page = 1'b1;
      pfsa_pkg::S_FREE: cmd.do_free  = 1'b1;
      pfsa_pkg::S_FIN:  cmd.finish   = 1'b1;
      default:          busy         = 1'b1;
    endcase
  end

endmodule

[design/pfsa_dp.sv]
module pfsa_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfsa_pkg::ctl_cmd_t                   cmd,
  output pfsa_pkg::dp_stat_t                   stat,
  input  logic [pfsa_pkg::PAGE_W-1:0]          in_free_page,
  input  logic [pfsa_pkg::IDX_W-1:0]           in_free_index,
  input  logic                                 cfg_we,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pfsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [pfsa_pkg::PAGE_W-1:0]          out_page,
  output logic [pfsa_pkg::IDX_W-1:0]           out_index,
  output logic [pfsa_pkg::OFF_W-1:0]           out_byte_offset,
  output logic [pfsa_pkg::LEN_W-1:0]           out_pages_in_use
);

  localparam int NP = pfsa_pkg::PAGE_SLOTS;
  localparam int NI = pfsa_pkg::ITEMS_MAX;
  localparam int PW = pfsa_pkg::PAGE_W;
  localparam int IW = pfsa_pkg::IDX_W;
  localparam int CW = pfsa_pkg::CNT_W;
  localparam int LW = pfsa_pkg::LEN_W;
  localparam int OW = pfsa_pkg::OFF_W;
  localparam int SW = pfsa_pkg::SIZE_W;

  // config
  logic [SW-1:0] item_size_r, item_size_nxt;
  logic [CW-1:0] ipp_r, ipp_nxt;

  // page state
  logic [NP-1:0]          active_r, active_nxt;
  logic [NP-1:0][CW-1:0]  count_r, count_nxt;
  logic [NP-1:0][NI-1:0]  map_r, map_nxt;
  logic [NP-1:0][PW-1:0]  order_r, order_nxt;
  logic [LW-1:0]          len_r, len_nxt;

  // request and walk
  logic [LW-1:0] k_r, k_nxt;
  logic [PW-1:0] req_page_r, req_page_nxt;
  logic [IW-1:0] req_index_r, req_index_nxt;

  // pending result
  pfsa_pkg::status_t res_status_r, res_status_nxt;
  logic [PW-1:0]     res_page_r, res_page_nxt;
  logic [IW-1:0]     res_index_r, res_index_nxt;
  logic              zero_off_r, zero_off_nxt;

  // output registers
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [PW-1:0] out_page_r, out_page_nxt;
  logic [IW-1:0] out_index_r, out_index_nxt;
  logic [OW-1:0] out_off_r, out_off_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;

  // scan helpers
  logic [CW-1:0] slots_n;
  logic [NI-1:0] slot_mask;
  logic [PW-1:0] cur_page;
  logic [NI-1:0] cur_free;
  logic [IW-1:0] low_idx;

  // new page helpers
  logic [PW-1:0] first_idle;
  logic          any_idle;

  // free helpers
  logic          free_bad;
  logic [NP-1:0] match;
  logic [NP-1:0] at_or_after;
  logic [NP-1:0][PW-1:0] order_del;

  // offset
  logic [OW-1:0]      stride;
  logic [OW+IW-1:0]   prod;

  // effective slots per page, clamped to 1..ITEMS_MAX
  always_comb begin
    if (ipp_r == '0) begin
      slots_n = CW'(1);
    end else if (ipp_r > CW'(NI)) begin
      slots_n = CW'(NI);
    end else begin
      slots_n = ipp_r;
    end
    if (slots_n >= CW'(NI)) begin
      slot_mask = '1;
    end else begin
      slot_mask = (NI'(1) << slots_n) - NI'(1);
    end
  end

  // one listed page per cycle
  assign cur_page = order_r[k_r[PW-1:0]];
  assign cur_free = map_r[cur_page] & slot_mask;

  always_comb begin
    low_idx = '0;
    for (int i = NI - 1; i >= 0; i--) begin
      if (cur_free[i]) begin
        low_idx = IW'(i);
      end
    end
  end

  assign stat.list_end = (k_r >= len_r);
  assign stat.page_hit = (count_r[cur_page] < slots_n) && (|cur_free);

  always_comb begin
    first_idle = '0;
    any_idle   = 1'b0;
    for (int p = NP - 1; p >= 0; p--) begin
      if (!active_r[p]) begin
        first_idle = PW'(p);
        any_idle   = 1'b1;
      end
    end
  end

  assign free_bad = !active_r[req_page_r] || map_r[req_page_r][req_index_r] ||
                    (count_r[req_page_r] == '0);

  // unlink: entries at and after the freed page move down by one
  always_comb begin
    for (int k = 0; k < NP; k++) begin
      match[k] = (order_r[k] == req_page_r) && (LW'(k) < len_r);
    end
    for (int k = 0; k < NP; k++) begin
      at_or_after[k] = |(match & (NP'({NP{1'b1}}) >> (NP - 1 - k)));
    end
    for (int k = 0; k < NP; k++) begin
      if (at_or_after[k] && (k < NP - 1)) begin
        order_del[k] = order_r[(k + 1) % NP];
      end else begin
        order_del[k] = order_r[k];
      end
    end
  end

  assign stride = OW'(item_size_r) + OW'(pfsa_pkg::SLOT_HDR_BYTES);
  assign prod   = res_index_r * stride;

  always_comb begin
    item_size_nxt  = item_size_r;
    ipp_nxt        = ipp_r;
    active_nxt     = active_r;
    count_nxt      = count_r;
    map_nxt        = map_r;
    order_nxt      = order_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    req_page_nxt   = req_page_r;
    req_index_nxt  = req_index_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_index_nxt  = res_index_r;
    zero_off_nxt   = zero_off_r;
    out_valid_nxt  = cmd.finish;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_index_nxt  = out_index_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;

    if (cfg_we) begin
      unique case (cfg_index)
        pfsa_pkg::REG_ITEM_SIZE:      item_size_nxt = cfg_data[SW-1:0];
        pfsa_pkg::REG_ITEMS_PER_PAGE: ipp_nxt       = cfg_data[CW-1:0];
        default:                      ipp_nxt       = ipp_r;
      endcase
    end

    if (cmd.latch) begin
      req_page_nxt  = in_free_page;
      req_index_nxt = in_free_index;
      k_nxt         = '0;
    end

    if (cmd.step) begin
      k_nxt = k_r + LW'(1);
    end

    if (cmd.take) begin
      map_nxt[cur_page][low_idx] = 1'b0;
      count_nxt[cur_page]        = count_r[cur_page] + CW'(1);
      res_status_nxt             = pfsa_pkg::ST_ALLOC;
      res_page_nxt               = cur_page;
      res_index_nxt              = low_idx;
      zero_off_nxt               = 1'b0;
    end

    if (cmd.new_page) begin
      res_index_nxt = '0;
      if (any_idle) begin
        active_nxt[first_idle] = 1'b1;
        count_nxt[first_idle]  = CW'(1);
        map_nxt[first_idle]    = {{(NI-1){1'b1}}, 1'b0};
        for (int k = 1; k < NP; k++) begin
          order_nxt[k] = order_r[k - 1];
        end
        order_nxt[0] = first_idle;
        if (len_r < LW'(NP)) begin
          len_nxt = len_r + LW'(1);
        end
        res_status_nxt = pfsa_pkg::ST_ALLOC_NEW;
        res_page_nxt   = first_idle;
        zero_off_nxt   = 1'b0;
      end else begin
        res_status_nxt = pfsa_pkg::ST_NO_PAGE;
        res_page_nxt   = '0;
        zero_off_nxt   = 1'b1;
      end
    end

    if (cmd.do_free) begin
      res_page_nxt  = req_page_r;
      res_index_nxt = req_index_r;
      if (free_bad) begin
        res_status_nxt = pfsa_pkg::ST_BAD_FREE;
        zero_off_nxt   = 1'b1;
      end else begin
        zero_off_nxt                      = 1'b0;
        map_nxt[req_page_r][req_index_r]  = 1'b1;
        count_nxt[req_page_r]             = count_r[req_page_r] - CW'(1);
        if (count_r[req_page_r] == CW'(1)) begin
          active_nxt[req_page_r] = 1'b0;
          order_nxt              = order_del;
          len_nxt                = len_r - LW'(1);
          res_status_nxt         = pfsa_pkg::ST_RELEASED;
        end else begin
          res_status_nxt = pfsa_pkg::ST_FREED;
        end
      end
    end

    if (cmd.finish) begin
      out_status_nxt = 3'(res_status_r);
      out_page_nxt   = res_page_r;
      out_index_nxt  = res_index_r;
      out_len_nxt    = len_r;
      if (zero_off_r) begin
        out_off_nxt = '0;
      end else begin
        out_off_nxt = prod[OW-1:0] +
                      OW'(pfsa_pkg::HEADER_BYTES + pfsa_pkg::SLOT_HDR_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_size_r <= pfsa_pkg::ITEM_SIZE_RST;
      ipp_r       <= pfsa_pkg::IPP_RST;
      active_r    <= '0;
      count_r     <= '0;
      len_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      item_size_r <= item_size_nxt;
      ipp_r       <= ipp_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      len_r       <= len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    map_r        <= map_nxt;
    order_r      <= order_nxt;
    req_page_r   <= req_page_nxt;
    req_index_r  <= req_index_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_index_r  <= res_index_nxt;
    zero_off_r   <= zero_off_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_index_r  <= out_index_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_page         = out_page_r;
  assign out_index        = out_index_r;
  assign out_byte_offset  = out_off_r;
  assign out_pages_in_use = out_len_r;

endmodule

[bench/pfsa_checker.sv]
`default_nettype none

module pfsa_checker
  import pfsa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  in_command,
  input  wire logic [PAGE_W-1:0]     in_free_page,
  input  wire logic [IDX_W-1:0]      in_free_index,
  input  wire logic                  out_valid,
  input  wire logic [2:0]            out_status,
  input  wire logic [PAGE_W-1:0]     out_page,
  input  wire logic [IDX_W-1:0]      out_index,
  input  wire logic [OFF_W-1:0]      out_byte_offset,
  input  wire logic [LEN_W-1:0]      out_pages_in_use,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  run_over,
  output int                         fail_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page;
    logic [IDX_W-1:0]  index;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  pages;
  } outcome_t;

  // shadow of the allocator
  bit                 page_live [PAGE_SLOTS];
  bit [CNT_W-1:0]     page_fill [PAGE_SLOTS];
  bit [ITEMS_MAX-1:0] vacancy   [PAGE_SLOTS];
  bit [PAGE_W-1:0]    page_list [PAGE_SLOTS];
  int                 list_len;
  bit [SIZE_W-1:0]    item_bytes;
  bit [CNT_W-1:0]     slot_cfg;

  outcome_t pending_outcomes[$];
  bit       wrapped_up;

  initial fail_count = 0;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // one allocate or free against the shadow state
  function automatic outcome_t apply_request(input logic cmd, input logic [PAGE_W-1:0] fp,
                                             input logic [IDX_W-1:0] fi);
    outcome_t    o;
    int          lim, k, i, w, p, spot;
    int unsigned span;
    bit          hit;
    o = '0;
    hit = 1'b0;
    lim = (slot_cfg == 0) ? 1 : (slot_cfg > ITEMS_MAX) ? ITEMS_MAX : int'(slot_cfg);
    if (cmd == CMD_ALLOC) begin
      for (k = 0; k < list_len && !hit; k++) begin
        p = page_list[k];
        if (page_fill[p] < lim) begin
          for (i = 0; i < lim && !hit; i++) begin
            if (vacancy[p][i]) begin
              vacancy[p][i] = 1'b0;
              page_fill[p]++;
              o.status = ST_ALLOC;
              o.page = PAGE_W'(p);
              o.index = IDX_W'(i);
              hit = 1'b1;
            end
          end
        end
      end
      if (!hit) begin
        spot = -1;
        for (p = PAGE_SLOTS - 1; p >= 0; p--)
          if (!page_live[p]) spot = p;
        if (spot < 0) begin
          o.status = ST_NO_PAGE;
        end else begin
          page_live[spot] = 1'b1;
          page_fill[spot] = 1;
          vacancy[spot] = '1;
          vacancy[spot][0] = 1'b0;
          for (k = list_len; k > 0; k--)
            if (k < PAGE_SLOTS) page_list[k] = page_list[k-1];
          page_list[0] = PAGE_W'(spot);
          if (list_len < PAGE_SLOTS) list_len++;
          o.status = ST_ALLOC_NEW;
          o.page = PAGE_W'(spot);
          o.index = '0;
          hit = 1'b1;
        end
      end
    end else begin
      o.page = fp;
      o.index = fi;
      if (!page_live[fp] || vacancy[fp][fi] || page_fill[fp] == 0) begin
        o.status = ST_BAD_FREE;
      end else begin
        vacancy[fp][fi] = 1'b1;
        page_fill[fp]--;
        hit = 1'b1;
        if (page_fill[fp] == 0) begin
          page_live[fp] = 1'b0;
          w = 0;
          for (k = 0; k < list_len; k++) begin
            if (page_list[k] != fp) begin
              page_list[w] = page_list[k];
              w++;
            end
          end
          list_len = w;
          o.status = ST_RELEASED;
        end else begin
          o.status = ST_FREED;
        end
      end
    end
    if (hit) begin
      span = HEADER_BYTES + o.index * (item_bytes + SLOT_HDR_BYTES) + SLOT_HDR_BYTES;
      o.offset = span[OFF_W-1:0];
    end
    o.pages = list_len[LEN_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      for (int p = 0; p < PAGE_SLOTS; p++) begin
        page_live[p] = 1'b0;
        page_fill[p] = '0;
        vacancy[p] = '0;
        page_list[p] = '0;
      end
      list_len = 0;
      item_bytes = ITEM_SIZE_RST;
      slot_cfg = IPP_RST;
      pending_outcomes.delete();
      wrapped_up = 1'b0;
    end else begin
      if (out_valid) begin
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("result with no item outstanding, status", out_status, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (out_status != want.status)
            flag_mismatch("status", out_status, want.status);
          if (out_page != want.page)
            flag_mismatch("page", out_page, want.page);
          if (out_index != want.index)
            flag_mismatch("index", out_index, want.index);
          if (out_byte_offset != want.offset)
            flag_mismatch("byte_offset", out_byte_offset, want.offset);
          if (out_pages_in_use != want.pages)
            flag_mismatch("pages_in_use", out_pages_in_use, want.pages);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_ITEM_SIZE:      item_bytes = cfg_data[SIZE_W-1:0];
          REG_ITEMS_PER_PAGE: slot_cfg = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        pending_outcomes.push_back(apply_request(in_command, in_free_page, in_free_index));
      if (run_over && !wrapped_up) begin
        wrapped_up = 1'b1;
        if (pending_outcomes.size() != 0)
          flag_mismatch("items left without a result", pending_outcomes.size(), 0);
      end
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;

  import pfsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with nothing accepted on either channel before giving up
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 228;
  localparam int SEGMENT     = 38;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = CMD_ALLOC;
  logic [PAGE_W-1:0]     in_free_page = '0;
  logic [IDX_W-1:0]      in_free_index = '0;
  logic                  out_valid;
  logic [2:0]            out_status;
  logic [PAGE_W-1:0]     out_page;
  logic [IDX_W-1:0]      out_index;
  logic [OFF_W-1:0]      out_byte_offset;
  logic [LEN_W-1:0]      out_pages_in_use;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ITEM_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  run_over = 1'b0;
  int                    fail_count;

  // bookkeeping for stimulus only: what the block has handed out so far
  int                          issued = 0;
  int                          returned = 0;
  int                          quiet_cycles = 0;
  bit                          idle_on = 1'b1;
  bit                          started_pages [PAGE_SLOTS];
  logic [PAGE_W+IDX_W-1:0]     live_slots[$];

  // per phase settings: item size and slots per page (upper data bits random)
  int phase_sizes [PHASES] = '{2047, 0, 1234, 7, 100, 55, 300, 0};
  int phase_slots [PHASES] = '{1, 2, 3, 0, 100, 127, 5, 0};

  always #5 clk = ~clk;

  paged_fixed_slot_allocator_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_free_page     (in_free_page),
    .in_free_index    (in_free_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_page         (out_page),
    .out_index        (out_index),
    .out_byte_offset  (out_byte_offset),
    .out_pages_in_use (out_pages_in_use),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  pfsa_checker pfsa_watch (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_free_page     (in_free_page),
    .in_free_index    (in_free_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_page         (out_page),
    .out_index        (out_index),
    .out_byte_offset  (out_byte_offset),
    .out_pages_in_use (out_pages_in_use),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .run_over         (run_over),
    .fail_count       (fail_count)
  );

  // follow the results so that frees mostly target slots really in use
  always @(posedge clk) begin
    int hit;
    if (rst_n && out_valid) begin
      returned++;
      case (status_t'(out_status))
        ST_ALLOC, ST_ALLOC_NEW: begin
          live_slots.push_back({out_page, out_index});
          if (status_t'(out_status) == ST_ALLOC_NEW) started_pages[out_page] = 1'b1;
        end
        ST_FREED, ST_RELEASED: begin
          hit = -1;
          foreach (live_slots[j])
            if (live_slots[j] == {out_page, out_index}) hit = j;
          if (hit >= 0) live_slots.delete(hit);
        end
        default: ;
      endcase
    end
  end

  // watchdog: nothing taken in and nothing coming out for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // register write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // present one item, with an occasional idle burst first, and hold it until taken
  task automatic send_item(input logic cmd, input logic [PAGE_W-1:0] pg,
                           input logic [IDX_W-1:0] ix);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_free_page = pg;
    in_free_index = ix;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // drop start and wait until every item has its result
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (returned != issued) @(negedge clk);
  endtask

  // mostly well-formed traffic: allocates and frees of live slots, some stray frees
  task automatic random_item(input int alloc_pct);
    int                r, j;
    logic [PAGE_W-1:0] pg;
    r = $urandom_range(0, 99);
    pg = PAGE_W'($urandom);
    if (r < alloc_pct || live_slots.size() == 0) begin
      send_item(CMD_ALLOC, pg, IDX_W'($urandom));
    end else if (r < 90) begin
      j = $urandom_range(0, live_slots.size() - 1);
      send_item(CMD_FREE, live_slots[j][PAGE_W+IDX_W-1:IDX_W], live_slots[j][IDX_W-1:0]);
    end else if (started_pages[pg]) begin
      // stray free on a page that has been set up at least once
      send_item(CMD_FREE, pg, IDX_W'($urandom));
    end else begin
      send_item(CMD_ALLOC, pg, IDX_W'($urandom));
    end
  endtask

  initial begin
    int sz, sl;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: items of 2024 bytes, one slot per page so the page slots run out fast
    write_reg(REG_ITEM_SIZE, CFG_DATA_W'(2024));
    write_reg(REG_ITEMS_PER_PAGE, CFG_DATA_W'(1));
    repeat (PAGE_SLOTS) send_item(CMD_ALLOC, PAGE_W'($urandom), IDX_W'($urandom));
    // every page slot taken
    send_item(CMD_ALLOC, '1, '1);
    // release a page, then free it again while inactive
    send_item(CMD_FREE, PAGE_W'(3), '0);
    send_item(CMD_FREE, PAGE_W'(3), '0);
    // slot never handed out, top index, and a slot already free
    send_item(CMD_FREE, PAGE_W'(15), IDX_W'(63));
    send_item(CMD_FREE, PAGE_W'(7), IDX_W'(5));
    // lowest inactive slot comes back at the head of the list
    send_item(CMD_ALLOC, '0, '0);
    settle();

    // more slots per page while pages are live; offsets wrap past the 12-bit offset width
    write_reg(REG_ITEMS_PER_PAGE, CFG_DATA_W'(64));
    repeat (3) send_item(CMD_ALLOC, PAGE_W'($urandom), IDX_W'($urandom));
    send_item(CMD_FREE, PAGE_W'(3), IDX_W'(1));

    // random phases, alternating fill and drain stretches
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      sz = (ph == PHASES - 1) ? $urandom_range(1, 2024) : phase_sizes[ph];
      sl = (ph == PHASES - 1) ? $urandom_range(1, 8) : phase_slots[ph];
      write_reg(REG_ITEM_SIZE, CFG_DATA_W'(sz));
      write_reg(REG_ITEMS_PER_PAGE, {4'($urandom), 7'(sl)});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // no idling at all in the closing phase
        if (n % SEGMENT == 0)
          idle_on = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
        random_item(((n / SEGMENT) % 2 == 0) ? 75 : 25);
      end
    end

    settle();
    repeat (30) @(posedge clk);
    @(negedge clk);
    run_over = 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
design/pfsa_pkg.sv
design/pfsa_ctrl.sv
design/pfsa_dp.sv
design/paged_fixed_slot_allocator_core.sv
bench/pfsa_checker.sv
bench/tb_top.sv
